// File: rtl/bitmap_block_allocator_unit_macros.svh
// ----------------------------------------------------------------------------
// Bitmap block allocator - assertion macros
// Shared concurrent assertion forms for the allocator modules.
// ----------------------------------------------------------------------------
`ifndef BITMAP_BLOCK_ALLOCATOR_UNIT_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_UNIT_MACROS_SVH

// same-cycle implication
`define BBA_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bba: same-cycle check failed");

// next-cycle implication
`define BBA_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bba: next-cycle check failed");

`endif

// File: rtl/bba_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap block allocator - package
// Field widths, operation and status codes, payload and control structs.
// ----------------------------------------------------------------------------
package bba_pkg;

   localparam int OP_W        = 2;
   localparam int ADDR_W      = 32;
   localparam int STATUS_W    = 2;
   localparam int COUNT_W     = 7;
   localparam int SIZE_W      = 13;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 32;
   localparam int STRIDE_W    = 14;  // 13-bit block_size plus both guards
   localparam int REM_W       = 20;  // covers 127 blocks of the largest stride
   localparam int DIV_STEPS   = 7;   // quotient bits, index is always below 128
   localparam int DIVK_W      = 3;
   localparam int CHUNK_BITS  = 16;
   localparam int CHUNK_POS_W = 4;
   localparam int MAX_COUNT   = 127;

   localparam logic [SIZE_W-1:0]  BLOCK_SIZE_RESET  = 13'd64;
   localparam logic [COUNT_W-1:0] BLOCK_COUNT_RESET = 7'd64;

   localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
   localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOTALLOC = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_POOL_BASE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_SIZE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_COUNT = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]   operation;
      logic [ADDR_W-1:0] address;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ADDR_W-1:0]   block_address;
      logic                allocated;
      logic [COUNT_W-1:0]  free_blocks;
   } rsp_type;

   typedef struct packed {
      logic load_req;
      logic calc_map;
      logic check;
      logic div_step;
      logic scan_step;
      logic mult;
      logic finish;
   } ctl_cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] in_op;
      logic            pool_empty;
      logic            range_bad;
      logic            div_last;
      logic            scan_hit;
      logic            out_busy;
   } dp_sts_type;

endpackage

// File: rtl/bitmap_block_allocator_unit.sv
// ----------------------------------------------------------------------------
// Bitmap block allocator unit
// Fixed-size block allocator with a guarded stride, bitmap and free count.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : request channel (operation, address), valid/stall handshake.
//   rsp_*  : one result per request (status, block_address, allocated,
//            free_blocks), valid/stall handshake.
//   csr_*  : register writes, index 0 pool_base, 1 block_size, 2 block_count;
//            write only while no request is in flight.
// One request is worked on at a time; a transfer on req_* is taken only in
// idle. Steps from request transfer to the result register:
//   allocate    : scan, multiply, finish; the lowest-free scan visits 1 to
//                 ceil(min(MAX_BLOCKS,127)/16) 16-bit bitmap chunks
//   pool full   : finish only
//   free, query : map, check, the 7-step restoring divide by the stride,
//                 finish; map, check, finish when the address is out of range
//   other codes : finish only
// The result sits in an output register, so the next request is taken while
// it waits; a stalled receiver only holds a later request in its last step.
// Reset clears the bitmap at once and sets the free count to 64, capped by the map depth.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_unit #(
   parameter int MAX_BLOCKS  = 64,
   parameter int GUARD_BYTES = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  bba_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output bba_pkg::rsp_type               rsp_data,
   input  logic                           csr_we,
   input  logic [bba_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bba_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import bba_pkg::*;

   ctl_cmd_type cmd;
   dp_sts_type  sts;

   bba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   bba_dpath #(
      .MAX_BLOCKS  (MAX_BLOCKS),
      .GUARD_BYTES (GUARD_BYTES)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

// File: rtl/bba_ctrl.sv
// ----------------------------------------------------------------------------
// Bitmap block allocator - controller
// Sequences one request at a time through map, check, divide, scan, multiply and finish.
// ----------------------------------------------------------------------------
`include "bitmap_block_allocator_unit_macros.svh"

module bba_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output bba_pkg::ctl_cmd_type cmd,
   input  bba_pkg::dp_sts_type  sts
);
   import bba_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_MAP    = 7'b0000010,
      ST_CHECK  = 7'b0000100,
      ST_DIV    = 7'b0001000,
      ST_SCAN   = 7'b0010000,
      ST_MULT   = 7'b0100000,
      ST_FINISH = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               case (sts.in_op)
                  OP_ALLOC: state_in = sts.pool_empty ? ST_FINISH : ST_SCAN;
                  OP_FREE:  state_in = ST_MAP;
                  OP_QUERY: state_in = ST_MAP;
                  default:  state_in = ST_FINISH;
               endcase
            end
         end
         ST_MAP: begin
            cmd.calc_map = 1'b1;
            state_in     = ST_CHECK;
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            state_in  = sts.range_bad ? ST_FINISH : ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) state_in = ST_FINISH;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_hit) state_in = ST_MULT;
         end
         ST_MULT: begin
            cmd.mult = 1'b1;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            // hold until the output register can take the result
            if (!sts.out_busy) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   `BBA_ASSERT_IMP(a_one_command, clock, reset, 1'b1, $onehot0(cmd))
   `BBA_ASSERT_NXT(a_busy_after_take, clock, reset, cmd.load_req, req_stall)

endmodule

// File: rtl/bba_dpath.sv
// ----------------------------------------------------------------------------
// Bitmap block allocator - datapath
// Config registers, allocation bitmap, free count, restoring divider,
// chunked lowest-free search, address multiply and the output register.
// ----------------------------------------------------------------------------
`include "bitmap_block_allocator_unit_macros.svh"

module bba_dpath #(
   parameter int MAX_BLOCKS  = 64,
   parameter int GUARD_BYTES = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [bba_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [bba_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  bba_pkg::req_type                    req_data,
   input  logic                                rsp_stall,
   output logic                                rsp_valid,
   output bba_pkg::rsp_type                    rsp_data,
   input  bba_pkg::ctl_cmd_type                cmd,
   output bba_pkg::dp_sts_type                 sts
);
   import bba_pkg::*;

   localparam int MAP_DEPTH  = (MAX_BLOCKS < MAX_COUNT) ? MAX_BLOCKS : MAX_COUNT;
   localparam int IDX_W      = $clog2(MAP_DEPTH);
   localparam int NUM_CHUNKS = (MAP_DEPTH + CHUNK_BITS - 1) / CHUNK_BITS;
   localparam int CHUNK_W    = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
   localparam int SCAN_W     = NUM_CHUNKS * CHUNK_BITS;
   localparam int ADDR_XW    = ADDR_W + 1;
   localparam logic [COUNT_W-1:0] DEPTH_COUNT = COUNT_W'(MAP_DEPTH);
   localparam logic [COUNT_W-1:0] FREE_RESET  =
      (DEPTH_COUNT < BLOCK_COUNT_RESET) ? DEPTH_COUNT : BLOCK_COUNT_RESET;
   localparam logic [STRIDE_W-1:0] GUARD_PAIR = STRIDE_W'(2 * GUARD_BYTES);
   localparam logic [ADDR_XW-1:0]  GUARD_X    = ADDR_XW'(GUARD_BYTES);
   localparam logic [ADDR_W-1:0]   GUARD_A    = ADDR_W'(GUARD_BYTES);

   // configuration
   logic [ADDR_W-1:0]  pool_base_ff, pool_base_in;
   logic [SIZE_W-1:0]  block_size_ff, block_size_in;
   logic [COUNT_W-1:0] block_count_ff, block_count_in;
   // allocator state
   logic [MAP_DEPTH-1:0] used_map_ff, used_map_in;
   logic [COUNT_W-1:0]   free_ff, free_in;
   // per-request working registers
   logic [OP_W-1:0]    op_ff, op_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic               below_ff, below_in;
   logic [ADDR_W-1:0]  diff_ff, diff_in;
   logic [REM_W-1:0]   limit_ff, limit_in;
   logic               range_bad_ff, range_bad_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [DIVK_W-1:0]  divk_ff, divk_in;
   logic [COUNT_W-1:0] idx_ff, idx_in;
   logic [CHUNK_W-1:0] chunk_ff, chunk_in;
   logic [REM_W-1:0]   prod_ff, prod_in;
   // output register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic [COUNT_W-1:0]     eff_count, csr_eff_count;
   logic [STRIDE_W-1:0]    stride;
   logic [ADDR_XW-1:0]     user_start;
   logic                   range_bad;
   logic [REM_W:0]         trial;
   logic [SCAN_W-1:0]      scan_vec;
   logic [CHUNK_BITS-1:0]  chunk_free;
   logic [CHUNK_POS_W-1:0] free_pos;
   logic                   scan_hit;
   logic                   used_bit;
   logic                   count_write;
   rsp_type                result;
   logic                   map_set, map_clr;
   logic [COUNT_W-1:0]     free_next;

   assign eff_count     = (block_count_ff > DEPTH_COUNT) ? DEPTH_COUNT : block_count_ff;
   assign csr_eff_count = (csr_wdata[COUNT_W-1:0] > DEPTH_COUNT) ? DEPTH_COUNT
                                                                 : csr_wdata[COUNT_W-1:0];
   assign stride     = ((block_size_ff == '0) ? STRIDE_W'(1) : STRIDE_W'(block_size_ff))
                       + GUARD_PAIR;
   assign user_start = {1'b0, pool_base_ff} + GUARD_X;
   assign range_bad  = below_ff || (diff_ff >= ADDR_W'(limit_ff));
   assign trial      = {1'b0, rem_ff} - {1'b0, REM_W'(stride) << divk_ff};
   assign used_bit   = used_map_ff[idx_ff[IDX_W-1:0]];
   assign count_write = csr_we && (csr_index == CSR_BLOCK_COUNT);

   // lowest free bit, one chunk of the bitmap per cycle; padding reads as used
   always_comb begin
      scan_vec                  = '1;
      scan_vec[MAP_DEPTH-1:0]   = used_map_ff;
      chunk_free = ~scan_vec[chunk_ff*CHUNK_BITS +: CHUNK_BITS];
      free_pos   = '0;
      for (int i = CHUNK_BITS - 1; i >= 0; i--) begin
         if (chunk_free[i]) free_pos = CHUNK_POS_W'(i);
      end
   end
   assign scan_hit = |chunk_free;

   // result and state update of the finishing request
   always_comb begin
      result    = '0;
      map_set   = 1'b0;
      map_clr   = 1'b0;
      free_next = free_ff;
      case (op_ff)
         OP_ALLOC: begin
            if (free_ff == '0) begin
               result.status = ST_FULL;
            end else begin
               result.block_address = pool_base_ff + ADDR_W'(prod_ff) + GUARD_A;
               map_set   = 1'b1;
               free_next = free_ff - COUNT_W'(1);
            end
         end
         OP_FREE: begin
            if (range_bad_ff) begin
               result.status = ST_RANGE;
            end else if (!used_bit) begin
               result.status = ST_NOTALLOC;
            end else begin
               map_clr   = 1'b1;
               free_next = free_ff + COUNT_W'(1);
            end
         end
         OP_QUERY: begin
            if (range_bad_ff) result.status = ST_RANGE;
            else              result.allocated = used_bit;
         end
         default: result.status = ST_OK;
      endcase
      result.free_blocks = free_next;
   end

   always_comb begin
      pool_base_in   = pool_base_ff;
      block_size_in  = block_size_ff;
      block_count_in = block_count_ff;
      used_map_in    = used_map_ff;
      free_in        = free_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_POOL_BASE:   pool_base_in   = csr_wdata[ADDR_W-1:0];
            CSR_BLOCK_SIZE:  block_size_in  = csr_wdata[SIZE_W-1:0];
            CSR_BLOCK_COUNT: block_count_in = csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end
      if (count_write) begin
         used_map_in = '0;
         free_in     = csr_eff_count;
      end else if (cmd.finish) begin
         if (map_set) used_map_in[idx_ff[IDX_W-1:0]] = 1'b1;
         if (map_clr) used_map_in[idx_ff[IDX_W-1:0]] = 1'b0;
         free_in = free_next;
      end
   end

   always_comb begin
      op_in        = cmd.load_req ? req_data.operation : op_ff;
      addr_in      = cmd.load_req ? req_data.address : addr_ff;
      chunk_in     = cmd.load_req ? '0 : chunk_ff;
      below_in     = below_ff;
      diff_in      = diff_ff;
      limit_in     = limit_ff;
      range_bad_in = range_bad_ff;
      rem_in       = rem_ff;
      divk_in      = divk_ff;
      idx_in       = idx_ff;
      prod_in      = prod_ff;
      if (cmd.calc_map) begin
         below_in = ({1'b0, addr_ff} < user_start);
         diff_in  = addr_ff - pool_base_ff - GUARD_A;
         limit_in = REM_W'(eff_count) * REM_W'(stride);
      end
      if (cmd.check) begin
         // in range means diff is below limit, so it fits the remainder
         range_bad_in = range_bad;
         rem_in       = diff_ff[REM_W-1:0];
         divk_in      = DIVK_W'(DIV_STEPS - 1);
         idx_in       = '0;
      end
      if (cmd.div_step) begin
         if (!trial[REM_W]) begin
            rem_in          = trial[REM_W-1:0];
            idx_in[divk_ff] = 1'b1;
         end
         divk_in = divk_ff - DIVK_W'(1);
      end
      if (cmd.scan_step) begin
         if (scan_hit) idx_in   = COUNT_W'({chunk_ff, free_pos});
         else          chunk_in = chunk_ff + CHUNK_W'(1);
      end
      if (cmd.mult) prod_in = REM_W'(idx_ff) * REM_W'(stride);
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_in       = result;
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_base_ff   <= '0;
         block_size_ff  <= BLOCK_SIZE_RESET;
         block_count_ff <= BLOCK_COUNT_RESET;
         used_map_ff    <= '0;
         free_ff        <= FREE_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         pool_base_ff   <= pool_base_in;
         block_size_ff  <= block_size_in;
         block_count_ff <= block_count_in;
         used_map_ff    <= used_map_in;
         free_ff        <= free_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      addr_ff      <= addr_in;
      below_ff     <= below_in;
      diff_ff      <= diff_in;
      limit_ff     <= limit_in;
      range_bad_ff <= range_bad_in;
      rem_ff       <= rem_in;
      divk_ff      <= divk_in;
      idx_ff       <= idx_in;
      chunk_ff     <= chunk_in;
      prod_ff      <= prod_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign sts.in_op      = req_data.operation;
   assign sts.pool_empty = (free_ff == '0);
   assign sts.range_bad  = range_bad;
   assign sts.div_last   = (divk_ff == '0);
   assign sts.scan_hit   = scan_hit;
   assign sts.out_busy   = rsp_valid_ff && rsp_stall;

   `BBA_ASSERT_IMP(a_free_bounded, clock, reset, 1'b1, free_ff <= eff_count)
   `BBA_ASSERT_NXT(a_alloc_takes_one, clock, reset, cmd.finish && !csr_we && (op_ff == OP_ALLOC) && (free_ff != '0), free_ff == $past(free_ff) - COUNT_W'(1))
   `BBA_ASSERT_IMP(a_div_step_bound, clock, reset, cmd.div_step, divk_ff <= DIVK_W'(DIV_STEPS - 1))

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap block allocator - testbench
// Drives allocate, free and query transfers into the allocator under random
// gaps and receiver stalls, predicts every result from its own copy of the
// bitmap, free count and registers, and checks each result field by field.
// Register settings are changed between phases only while the unit is idle.
// ----------------------------------------------------------------------------
module tb;
   import bba_pkg::*;

   localparam int MAX_BLOCKS  = 64;
   localparam int GUARD_BYTES = 4;
   localparam int SETTLE_CYCLES = 16;   // longest request latency plus margin
   localparam logic [OP_W-1:0]      OP_UNDEF   = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // allocator image
   bit [MAX_BLOCKS-1:0] used_map = '0;
   int unsigned         free_total = MAX_BLOCKS;
   logic [31:0]         pool_base_q = '0;
   logic [12:0]         block_size_q = BLOCK_SIZE_RESET;
   logic [6:0]          block_count_q = BLOCK_COUNT_RESET;

   rsp_type expected_rsp_q[$];
   int      error_count = 0;
   bit      req_gap_on = 1'b0;
   bit      rsp_hold_on = 1'b0;

   bitmap_block_allocator_unit #(
      .MAX_BLOCKS  (MAX_BLOCKS),
      .GUARD_BYTES (GUARD_BYTES)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #8_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------
   function automatic int unsigned pool_blocks();
      return (block_count_q > MAX_BLOCKS) ? MAX_BLOCKS : block_count_q;
   endfunction

   function automatic longint unsigned slot_stride();
      longint unsigned usable;
      usable = (block_size_q == 0) ? 64'd1 : 64'(block_size_q);
      return usable + 2 * GUARD_BYTES;
   endfunction

   function automatic longint unsigned first_user_byte();
      return 64'(pool_base_q) + GUARD_BYTES;
   endfunction

   function automatic logic [31:0] user_address(input int unsigned idx);
      return 32'(first_user_byte() + idx * slot_stride());
   endfunction

   function automatic bit locate_block(input logic [31:0] addr, output int unsigned idx);
      longint unsigned slot;
      idx = 0;
      if (64'(addr) < first_user_byte())
         return 1'b0;
      slot = (64'(addr) - first_user_byte()) / slot_stride();
      if (slot >= pool_blocks())
         return 1'b0;
      idx = int'(slot);
      return 1'b1;
   endfunction

   function automatic rsp_type predict_allocation(input req_type item);
      rsp_type     res;
      int unsigned idx;
      bit          hit;
      res = '0;
      res.status = ST_OK;
      case (item.operation)
         OP_ALLOC: begin
            hit = 1'b0;
            if (free_total != 0) begin
               for (int i = 0; i < pool_blocks(); i++) begin
                  if (!hit && !used_map[i]) begin
                     used_map[i] = 1'b1;
                     free_total--;
                     res.block_address = user_address(i);
                     hit = 1'b1;
                  end
               end
            end
            if (!hit)
               res.status = ST_FULL;
         end
         OP_FREE: begin
            if (!locate_block(item.address, idx))
               res.status = ST_RANGE;
            else if (!used_map[idx])
               res.status = ST_NOTALLOC;
            else begin
               used_map[idx] = 1'b0;
               free_total++;
            end
         end
         OP_QUERY: begin
            if (!locate_block(item.address, idx))
               res.status = ST_RANGE;
            else
               res.allocated = used_map[idx];
         end
         default: ;
      endcase
      res.free_blocks = 7'(free_total);
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // Result checking
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp_q.size() == 0) begin
            $error("result transfer with nothing expected: %h", rsp_data);
            error_count++;
         end else begin
            want = expected_rsp_q.pop_front();
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_data.status);
               error_count++;
            end
            if (rsp_data.block_address !== want.block_address) begin
               $error("block_address: expected %h, actual %h",
                      want.block_address, rsp_data.block_address);
               error_count++;
            end
            if (rsp_data.allocated !== want.allocated) begin
               $error("allocated: expected %0d, actual %0d",
                      want.allocated, rsp_data.allocated);
               error_count++;
            end
            if (rsp_data.free_blocks !== want.free_blocks) begin
               $error("free_blocks: expected %0d, actual %0d",
                      want.free_blocks, rsp_data.free_blocks);
               error_count++;
            end
         end
      end
   end

   // receiver stalls: mostly short, a few long, none started while rsp_hold_on is low
   initial begin : rsp_stall_gen
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (rsp_hold_on && $urandom_range(0, 9) < 3) begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                     : $urandom_range(0, 2);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   task automatic send_request(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr);
      req_type item;
      item.operation = op;
      item.address   = addr;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      expected_rsp_q.push_back(predict_allocation(item));
   endtask

   task automatic request_gap();
      int len;
      if (req_gap_on && $urandom_range(0, 3) == 0) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (len - 1) @(negedge clock);
      end
   endtask

   // drop valid, let every expected result arrive, then let the unit settle
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_rsp_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      wait_idle();
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_POOL_BASE:  pool_base_q = data;
         CSR_BLOCK_SIZE: block_size_q = data[12:0];
         CSR_BLOCK_COUNT: begin
            block_count_q = data[6:0];
            used_map      = '0;
            free_total    = pool_blocks();
         end
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // upper data bits carry junk; only the register's own width counts
   task automatic configure_pool(input logic [31:0] base, input logic [12:0] size,
                                 input logic [6:0] count, input bit set_count);
      write_register(CSR_POOL_BASE, base);
      write_register(CSR_BLOCK_SIZE, {19'($urandom()), size});
      if (set_count)
         write_register(CSR_BLOCK_COUNT, {25'($urandom()), count});
   endtask

   // any byte of a slot, from its user start up to the next user start
   function automatic logic [31:0] slot_address(input int unsigned idx);
      return 32'(first_user_byte() + idx * slot_stride()
                 + $urandom_range(0, int'(slot_stride() - 1)));
   endfunction

   task automatic random_request();
      int unsigned taken[$];
      int unsigned n;
      int unsigned pick;
      logic [OP_W-1:0]   op;
      logic [ADDR_W-1:0] addr;
      longint unsigned   pool_end;
      n    = pool_blocks();
      pick = $urandom_range(0, 99);
      op   = OP_ALLOC;
      addr = $urandom();
      for (int i = 0; i < n; i++)
         if (used_map[i])
            taken.push_back(i);
      pool_end = first_user_byte() + n * slot_stride();
      if (pick < 35) begin
         op = OP_ALLOC;
      end else if (pick < 65 && taken.size() != 0) begin
         op   = OP_FREE;
         addr = slot_address(taken[$urandom_range(0, taken.size() - 1)]);
      end else if (pick < 82 && n != 0) begin
         op   = $urandom_range(0, 1) ? OP_QUERY : OP_FREE;
         addr = slot_address($urandom_range(0, n - 1));
      end else if (pick < 90) begin
         op = OP_W'($urandom_range(0, 3));
         case ($urandom_range(0, 2))
            0:       addr = 32'(first_user_byte() - 1);
            1:       addr = 32'(pool_end);
            default: addr = 32'(pool_end - 1);
         endcase
      end else begin
         op = OP_W'($urandom_range(0, 3));
      end
      send_request(op, addr);
   endtask

   task automatic random_phase(input int items);
      req_gap_on  = $urandom_range(0, 3) != 0;
      rsp_hold_on = $urandom_range(0, 3) != 0;
      for (int i = 0; i < items; i++) begin
         if ($urandom_range(0, 149) == 0)
            wait_idle();
         else
            request_gap();
         random_request();
      end
   endtask

   function automatic logic [31:0] pick_base();
      case ($urandom_range(0, 4))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         2:       return 32'hFFFF_F000;
         3:       return 32'h0000_1000;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [12:0] pick_size();
      case ($urandom_range(0, 5))
         0:       return 13'd0;
         1:       return 13'd1;
         2:       return 13'd4096;
         3:       return 13'd8191;
         4:       return 13'($urandom_range(1, 64));
         default: return 13'($urandom());
      endcase
   endfunction

   function automatic logic [6:0] pick_count();
      case ($urandom_range(0, 7))
         0:       return 7'd0;
         1:       return 7'd1;
         2:       return 7'd64;
         3:       return 7'd127;
         4, 5:    return 7'($urandom_range(1, 8));
         default: return 7'($urandom_range(1, 64));
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   // reset settings: base 0, size 64, so the stride is 72 and block 0 starts at 4
   task automatic test_reset_settings();
      req_gap_on  = 1'b0;
      rsp_hold_on = 1'b0;
      send_request(OP_ALLOC, 32'hFFFF_FFFF);
      send_request(OP_ALLOC, 32'h0);
      send_request(OP_QUERY, 32'd75);       // last byte of block 0's slot
      send_request(OP_QUERY, 32'd3);        // one below the first user byte
      send_request(OP_FREE,  32'd76);
      send_request(OP_FREE,  32'd147);      // already free
      send_request(OP_QUERY, 32'd147);
      send_request(OP_UNDEF, 32'hFFFF_FFFF);
      send_request(OP_QUERY, 32'd4611);     // last slot of the pool
      send_request(OP_QUERY, 32'd4612);     // just past the pool
      send_request(OP_FREE,  32'hFFFF_FFFF);
   endtask

   task automatic test_pool_limits();
      req_gap_on  = 1'b1;
      rsp_hold_on = 1'b1;
      write_register(CSR_BLOCK_COUNT, 32'd1);
      send_request(OP_ALLOC, 32'h0);
      send_request(OP_ALLOC, 32'h0);        // pool full
      send_request(OP_FREE,  32'd76);       // index past the count
      send_request(OP_FREE,  32'd4);
      write_register(CSR_BLOCK_COUNT, 32'd0);
      send_request(OP_ALLOC, 32'h0);        // empty pool
      send_request(OP_QUERY, 32'd4);
      write_register(CSR_BLOCK_COUNT, 32'd127);
      send_request(OP_QUERY, 32'd4611);
      send_request(OP_QUERY, 32'd4612);
      // zero size counts as one; user addresses wrap past the top of memory
      configure_pool(32'hFFFF_FFFF, 13'd0, 7'd0, 1'b0);
      send_request(OP_ALLOC, 32'h0);
      send_request(OP_ALLOC, 32'h0);
      send_request(OP_FREE,  32'd3);
      configure_pool(32'h0, 13'd8191, 7'd0, 1'b0);
      send_request(OP_ALLOC, 32'h0);
      send_request(OP_QUERY, 32'd24600);
   endtask

   // base and size writes keep the bitmap, the unused index is ignored
   task automatic test_register_writes();
      configure_pool(32'h0000_2000, 13'd16, 7'd16, 1'b1);
      random_phase(40);
      write_register(CSR_UNUSED, $urandom());
      random_phase(30);
      configure_pool(32'h0000_2100, 13'd40, 7'd0, 1'b0);
      random_phase(40);
   endtask

   task automatic test_random_traffic();
      configure_pool(32'h0000_1000, 13'd1, 7'd8, 1'b1);
      random_phase(150);
      configure_pool(32'hFFFF_FFFF, 13'd4096, 7'd64, 1'b1);
      random_phase(100);
      configure_pool(32'hFFFF_0000, 13'd0, 7'd127, 1'b1);
      random_phase(150);
      configure_pool($urandom(), 13'd8191, 7'($urandom_range(1, 64)), 1'b1);
      random_phase(150);
      configure_pool(32'h0, 13'd4096, 7'd2, 1'b1);
      random_phase(100);
      for (int p = 0; p < 10; p++) begin
         configure_pool(pick_base(), pick_size(), pick_count(), $urandom_range(0, 3) != 0);
         random_phase(120);
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_settings();
      test_pool_limits();
      test_register_writes();
      test_random_traffic();
      wait_idle();
      if (error_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
